### hw/rtl/scsd_pkg.sv
// Package for the sound command stream decoder: event codes, phases, lookup tables.
`default_nettype none
package scsd_pkg;
  localparam int OffsetWidth = 16;

  localparam logic [2:0] EV_WRITE   = 3'd0;
  localparam logic [2:0] EV_WAIT    = 3'd1;
  localparam logic [2:0] EV_LOOP    = 3'd2;
  localparam logic [2:0] EV_RESTART = 3'd3;
  localparam logic [2:0] EV_STOP    = 3'd4;
  localparam logic [2:0] EV_NOTIFY  = 3'd5;

  localparam logic CFG_LOOP_ENABLE   = 1'b0;
  localparam logic CFG_SHORT_DEFAULT = 1'b1;

  typedef enum logic [2:0] {
    PH_OP, PH_VAL, PH_FILLVAL, PH_REGFILL, PH_REGCOPY, PH_COPY, PH_NOTIFY
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_EMIT, ST_RUN
  } state_t;

  function automatic logic [7:0] tone_map(input logic [3:0] i);
    case (i)
      4'd0: tone_map = 8'd0;
      4'd1: tone_map = 8'd1;
      4'd2: tone_map = 8'd3;
      4'd3: tone_map = 8'd5;
      4'd4, 4'd5: tone_map = 8'd6;
      4'd6, 4'd7: tone_map = 8'd8;
      4'd8, 4'd9: tone_map = 8'd9;
      4'd10, 4'd11: tone_map = 8'd10;
      default: tone_map = 8'd13;
    endcase
  endfunction

  function automatic logic [5:0] fm_count(input logic [3:0] i);
    case (i)
      4'd0: fm_count = 6'd8;
      4'd1, 4'd2, 4'd3: fm_count = 6'd9;
      default: fm_count = 6'd3;
    endcase
  endfunction

  function automatic logic [7:0] fm_base(input logic [3:0] i);
    case (i)
      4'd0: fm_base = 8'h00;
      4'd1: fm_base = 8'h10;
      4'd2: fm_base = 8'h20;
      4'd3: fm_base = 8'h30;
      4'd4: fm_base = 8'h16;
      4'd5: fm_base = 8'h26;
      default: fm_base = 8'h36;
    endcase
  endfunction

  function automatic logic [7:0] wave_base(input logic [2:0] i);
    case (i)
      3'd0: wave_base = 8'h00;
      3'd1: wave_base = 8'h20;
      3'd2: wave_base = 8'h40;
      3'd3: wave_base = 8'h60;
      default: wave_base = 8'h80;
    endcase
  endfunction
endpackage
`default_nettype wire

### hw/rtl/sound_chip_command_stream_decoder.sv
// Sound chip command stream decoder: one stream byte in, register writes and song events out.
// Usage:
//   Input channel in_valid/in_stall/in_stream_byte takes one stream byte per beat.
//   Output channel out_valid/out_stall carries one event per beat; out_last_of_run
//   marks the final event caused by a byte. Bytes that cause no event give no beat.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_wdata writes loop_enable (index 0)
//   and short_default_value (index 1); write only while the block is idle.
// Timing and throughput:
//   A byte is decoded in the cycle it is accepted; its first event shows the next
//   cycle. A byte with no event leaves the input ready for the next byte. A fill run
//   issues one write per cycle while out_stall is low, through the register
//   incrementer and run counter. in_stall is high while a byte's events are still pending.
// Reset:
//   rst_n low clears the chip select, parse phase, offsets and config registers.
// Stall:
//   When out_stall is high the current event holds and the run does not advance.
`default_nettype none
module sound_chip_command_stream_decoder import scsd_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_stream_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [2:0]                  out_event_kind,
  output logic [2:0]                  out_target_chip,
  output logic [7:0]                  out_register_index,
  output logic [7:0]                  out_event_value,
  output logic [OffsetWidth-1:0]      out_stream_offset,
  output logic                        out_last_of_run,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire logic [7:0]             cfg_wdata
);
  state_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic [2:0] chip_r, chip_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic [OffsetWidth-1:0] pos_r, pos_nxt, loop_r, loop_nxt;
  logic loop_en_r;
  logic [7:0] sdef_r;
  logic [2:0] kind_r, kind_nxt;
  logic [7:0] oreg_r, oreg_nxt, val_r, val_nxt;
  logic [OffsetWidth-1:0] off_r, off_nxt;
  logic last_r, last_nxt;
  logic [7:0] fillv_r, fillv_nxt;
  logic acc, emit_one, start_run;
  logic [7:0] b;
  logic [3:0] hi, id;
  logic [OffsetWidth-1:0] pos_inc;

  assign acc = in_valid && !in_stall;
  assign b = in_stream_byte;
  assign hi = b[7:4];
  assign id = b[3:0];
  assign pos_inc = pos_r + 1'b1;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_stall = (st_r != ST_IDLE);
    out_valid = (st_r != ST_IDLE);
    out_event_kind = kind_r;
    out_target_chip = chip_r;
    out_register_index = oreg_r;
    out_event_value = val_r;
    out_stream_offset = off_r;
    out_last_of_run = last_r;
  end

  // Decode one byte, or advance a fill run.
  always_comb begin
    ph_nxt = ph_r; chip_nxt = chip_r; cnt_nxt = cnt_r; reg_nxt = reg_r;
    pos_nxt = pos_r; loop_nxt = loop_r; fillv_nxt = fillv_r;
    kind_nxt = kind_r; oreg_nxt = oreg_r; val_nxt = val_r; off_nxt = off_r;
    last_nxt = last_r; emit_one = 1'b0; start_run = 1'b0;
    if (acc) begin
      pos_nxt = pos_inc;
      kind_nxt = EV_WRITE; oreg_nxt = 8'd0; val_nxt = b; off_nxt = '0; last_nxt = 1'b1;
      case (ph_r)
        PH_VAL: begin
          emit_one = 1'b1; oreg_nxt = reg_r; cnt_nxt = '0; ph_nxt = PH_OP;
        end
        PH_FILLVAL: begin
          ph_nxt = PH_OP;
          fillv_nxt = b;
          if (cnt_r != '0) begin
            start_run = 1'b1; oreg_nxt = reg_r; last_nxt = (cnt_r == 6'd1);
            reg_nxt = reg_r + 8'd1; cnt_nxt = cnt_r - 6'd1;
          end
        end
        PH_REGFILL: begin reg_nxt = b; ph_nxt = PH_FILLVAL; end
        PH_REGCOPY: begin reg_nxt = b; ph_nxt = PH_COPY; end
        PH_COPY: begin
          emit_one = 1'b1; oreg_nxt = reg_r; reg_nxt = reg_r + 8'd1;
          if (cnt_r > 6'd1) cnt_nxt = cnt_r - 6'd1;
          else begin cnt_nxt = '0; ph_nxt = PH_OP; end
        end
        PH_NOTIFY: begin emit_one = 1'b1; kind_nxt = EV_NOTIFY; ph_nxt = PH_OP; end
        default: begin
          ph_nxt = PH_OP;
          if (hi == 4'hE) begin
            emit_one = 1'b1; kind_nxt = EV_WAIT; val_nxt = {4'd0, id} + 8'd1;
          end else if (hi == 4'hF) begin
            if (b <= 8'hF6) chip_nxt = id[2:0];
            else if (b == 8'hFD) ph_nxt = PH_NOTIFY;
            else if (b == 8'hFE) begin
              loop_nxt = pos_inc; emit_one = 1'b1; kind_nxt = EV_LOOP;
              val_nxt = 8'hFE; off_nxt = pos_inc;
            end else if (b == 8'hFF) begin
              emit_one = 1'b1;
              if (loop_en_r) begin
                kind_nxt = EV_RESTART; val_nxt = 8'hFF; off_nxt = loop_r; pos_nxt = loop_r;
              end else begin
                kind_nxt = EV_STOP; val_nxt = 8'd0; pos_nxt = '0;
              end
            end
          end else begin
            case (chip_r)
              3'd0: begin
                if (hi == 4'h0) begin cnt_nxt = 6'd1; reg_nxt = b; ph_nxt = PH_VAL; end
                else if (hi == 4'hD) begin
                  emit_one = 1'b1; oreg_nxt = {4'd0, id}; val_nxt = sdef_r;
                end else begin emit_one = 1'b1; oreg_nxt = tone_map(hi); end
              end
              3'd1: begin
                if (hi <= 4'h3) begin cnt_nxt = 6'd1; reg_nxt = b; ph_nxt = PH_VAL; end
                else if (hi == 4'h4 || hi == 4'h5) begin
                  if (id <= 4'd6) begin
                    cnt_nxt = fm_count(id); reg_nxt = fm_base(id);
                    ph_nxt = (hi == 4'h4) ? PH_COPY : PH_FILLVAL;
                  end
                end else if (hi == 4'h6) begin
                  cnt_nxt = {2'd0, id} + 6'd3; reg_nxt = '0; ph_nxt = PH_REGFILL;
                end else if (hi == 4'h7) begin
                  cnt_nxt = {2'd0, id} + 6'd3; reg_nxt = '0; ph_nxt = PH_REGCOPY;
                end else if (hi <= 4'hB) begin
                  emit_one = 1'b1; oreg_nxt = {1'b0, b[6:0]}; val_nxt = 8'd0;
                end
              end
              3'd2: begin cnt_nxt = 6'd1; reg_nxt = b; ph_nxt = PH_VAL; end
              3'd3: begin
                if (b < 8'hB0) begin cnt_nxt = 6'd1; reg_nxt = b; ph_nxt = PH_VAL; end
                else if (b < 8'hC0) begin
                  if (b[2:0] <= 3'd4) begin
                    cnt_nxt = 6'd32; reg_nxt = wave_base(b[2:0]);
                    ph_nxt = (b < 8'hB8) ? PH_COPY : PH_FILLVAL;
                  end
                end else if (b < 8'hD0) begin
                  cnt_nxt = {2'd0, id} + 6'd3; reg_nxt = '0; ph_nxt = PH_REGFILL;
                end else begin
                  cnt_nxt = {2'd0, id} + 6'd3; reg_nxt = '0; ph_nxt = PH_REGCOPY;
                end
              end
              default: ;
            endcase
          end
        end
      endcase
    end else if (st_r == ST_RUN && !out_stall && !last_r) begin
      // advance the fill run: one write per beat through the register incrementer
      oreg_nxt = reg_r; val_nxt = fillv_r; last_nxt = (cnt_r == 6'd1);
      reg_nxt = reg_r + 8'd1; cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (acc) begin
        if (start_run) st_nxt = ST_RUN;
        else if (emit_one) st_nxt = ST_EMIT;
      end
      ST_EMIT: if (!out_stall) st_nxt = ST_IDLE;
      ST_RUN: if (!out_stall && last_r) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ph_r <= PH_OP; chip_r <= '0; cnt_r <= '0; reg_r <= '0;
      pos_r <= '0; loop_r <= '0; loop_en_r <= 1'b0; sdef_r <= '0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; chip_r <= chip_nxt; cnt_r <= cnt_nxt;
      reg_r <= reg_nxt; pos_r <= pos_nxt; loop_r <= loop_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LOOP_ENABLE) loop_en_r <= cfg_wdata[0];
        else sdef_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt; oreg_r <= oreg_nxt; val_r <= val_nxt; off_r <= off_nxt;
    last_r <= last_nxt; fillv_r <= fillv_nxt;
  end

  a_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> (last_r == (cnt_r == 6'd0))) else $error("run count mismatch");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept while busy");
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT) |-> last_r) else $error("single event not last");
endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for the sound chip command stream decoder: directed and random byte streams.
`default_nettype none
module tb import scsd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]             kind;
    logic [2:0]             chip;
    logic [7:0]             regi;
    logic [7:0]             val;
    logic [OffsetWidth-1:0] off;
    logic                   last;
  } song_event_t;

  localparam logic [3:0] WAIT_NIBBLE = 4'hE;
  localparam logic [3:0] MARK_NIBBLE = 4'hF;
  localparam logic [7:0] MK_CHIP0  = 8'hF0;
  localparam logic [7:0] MK_NOTIFY = 8'hFD;
  localparam logic [7:0] MK_LOOP   = 8'hFE;
  localparam logic [7:0] MK_END    = 8'hFF;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_stream_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_event_kind, out_target_chip;
  logic [7:0] out_register_index, out_event_value;
  logic [OffsetWidth-1:0] out_stream_offset;
  logic out_last_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  sound_chip_command_stream_decoder i_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic       loop_on;
  logic [7:0] short_value;
  logic [2:0] cur_chip;
  phase_t     phase;
  logic [5:0] run_left;
  logic [7:0] run_reg;
  logic [OffsetWidth-1:0] byte_pos, loop_pos;

  logic [7:0] tone_tbl [13] = '{8'd0, 8'd1, 8'd3, 8'd5, 8'd6, 8'd6, 8'd8, 8'd8,
                                8'd9, 8'd9, 8'd10, 8'd10, 8'd13};
  logic [5:0] fm_cnt_tbl [7] = '{6'd8, 6'd9, 6'd9, 6'd9, 6'd3, 6'd3, 6'd3};
  logic [7:0] fm_base_tbl [7] = '{8'h00, 8'h10, 8'h20, 8'h30, 8'h16, 8'h26, 8'h36};
  logic [7:0] wave_tbl [5] = '{8'h00, 8'h20, 8'h40, 8'h60, 8'h80};

  song_event_t pending_events[$];
  int          run_events;
  int          errors = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          hold_left = 0;

  function automatic void add_event(logic [2:0] k, logic [7:0] r, logic [7:0] v,
                                    logic [OffsetWidth-1:0] o);
    song_event_t e;
    e = '{kind: k, chip: cur_chip, regi: r, val: v, off: o, last: 1'b0};
    pending_events.push_back(e);
    run_events++;
  endfunction

  function automatic void start_run(logic [5:0] cnt, logic [7:0] r, phase_t ph);
    run_left = cnt;
    run_reg = r;
    phase = ph;
  endfunction

  function automatic void decode_op(logic [7:0] b);
    logic [3:0] hi, id;
    hi = b[7:4];
    id = b[3:0];
    case (cur_chip)
      3'd0: begin
        if (hi == 4'h0) start_run(6'd1, b, PH_VAL);
        else if (hi == 4'hD) add_event(EV_WRITE, {4'h0, id}, short_value, '0);
        else if (hi <= 4'hC) add_event(EV_WRITE, tone_tbl[hi], b, '0);
      end
      3'd1: begin
        if (hi <= 4'h3) start_run(6'd1, b, PH_VAL);
        else if (hi == 4'h4 || hi == 4'h5) begin
          if (id <= 4'd6)
            start_run(fm_cnt_tbl[id], fm_base_tbl[id], hi == 4'h4 ? PH_COPY : PH_FILLVAL);
        end else if (hi == 4'h6) start_run(6'(id) + 6'd3, 8'h00, PH_REGFILL);
        else if (hi == 4'h7) start_run(6'(id) + 6'd3, 8'h00, PH_REGCOPY);
        else if (hi <= 4'hB) add_event(EV_WRITE, {1'b0, b[6:0]}, 8'h00, '0);
      end
      3'd2: start_run(6'd1, b, PH_VAL);
      3'd3: begin
        if (b < 8'hB0) start_run(6'd1, b, PH_VAL);
        else if (b < 8'hC0) begin
          if (b[2:0] <= 3'd4)
            start_run(6'd32, wave_tbl[b[2:0]], b < 8'hB8 ? PH_COPY : PH_FILLVAL);
        end else if (b < 8'hD0) start_run(6'(id) + 6'd3, 8'h00, PH_REGFILL);
        else start_run(6'(id) + 6'd3, 8'h00, PH_REGCOPY);
      end
      default: ;
    endcase
  endfunction

  // work out the events of one accepted stream byte
  function automatic void predict_byte(logic [7:0] b);
    logic adv;
    adv = 1'b1;
    run_events = 0;
    case (phase)
      PH_VAL: begin
        add_event(EV_WRITE, run_reg, b, '0);
        run_left = 0;
        phase = PH_OP;
      end
      PH_FILLVAL: begin
        for (int i = 0; i < run_left; i++) begin
          add_event(EV_WRITE, run_reg, b, '0);
          run_reg++;
        end
        run_left = 0;
        phase = PH_OP;
      end
      PH_REGFILL: begin run_reg = b; phase = PH_FILLVAL; end
      PH_REGCOPY: begin run_reg = b; phase = PH_COPY; end
      PH_COPY: begin
        add_event(EV_WRITE, run_reg, b, '0);
        run_reg++;
        if (run_left > 0) run_left--;
        if (run_left == 0) phase = PH_OP;
      end
      PH_NOTIFY: begin
        add_event(EV_NOTIFY, 8'h00, b, '0);
        phase = PH_OP;
      end
      default: begin
        phase = PH_OP;
        if (b[7:4] == WAIT_NIBBLE) add_event(EV_WAIT, 8'h00, 8'(b[3:0]) + 8'd1, '0);
        else if (b[7:4] == MARK_NIBBLE) begin
          if (b <= MK_CHIP0 + 8'd6) cur_chip = 3'(b - MK_CHIP0);
          else if (b == MK_NOTIFY) phase = PH_NOTIFY;
          else if (b == MK_LOOP) begin
            loop_pos = byte_pos + 1'b1;
            add_event(EV_LOOP, 8'h00, 8'hFE, loop_pos);
          end else if (b == MK_END) begin
            adv = 1'b0;
            if (loop_on) begin
              add_event(EV_RESTART, 8'h00, 8'hFF, loop_pos);
              byte_pos = loop_pos;
            end else begin
              add_event(EV_STOP, 8'h00, 8'h00, '0);
              byte_pos = '0;
            end
          end
        end else decode_op(b);
      end
    endcase
    if (adv) byte_pos = byte_pos + 1'b1;
    if (run_events > 0) pending_events[pending_events.size() - 1].last = 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] b);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_byte(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_LOOP_ENABLE) loop_on = v[0];
    else short_value = v;
  endtask

  // pick a byte that keeps the stream mostly well formed
  function automatic logic [7:0] pick_byte();
    int r;
    if (phase != PH_OP) return 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 12) return MK_CHIP0 + 8'($urandom_range(6));
    if (r < 17) return 8'($urandom_range(255, 8'hF7));
    if (r < 25) return 8'($urandom_range(8'hEF, 8'hE0));
    if (cur_chip == 3'd3 && r < 40) return 8'($urandom_range(8'hDF, 8'hB0));
    if (cur_chip == 3'd1 && r < 45) return 8'($urandom_range(8'h7F, 8'h40));
    return 8'($urandom_range(8'hDF));
  endfunction

  task automatic test_chip0_and_markers();
    logic [7:0] seq [] = '{8'h0F, 8'h00, 8'h00, 8'hFF, 8'hD5, 8'h10, 8'hCF, 8'hE0, 8'hEF,
                            8'hFE, 8'hF7, 8'hFC, 8'hFD, 8'h80, 8'hFF};
    foreach (seq[i]) send_byte(seq[i]);
    drain();
    write_cfg(CFG_LOOP_ENABLE, 8'h01);
    write_cfg(CFG_SHORT_DEFAULT, 8'hFF);
    send_byte(8'hDF);
    send_byte(MK_END);
    drain();
  endtask

  task automatic test_chip_tables();
    logic [7:0] seq [] = '{8'hF1, 8'h46, 8'h5F, 8'h47, 8'h60, 8'hFF, 8'h55, 8'hAA, 8'hC0,
                            8'hF3, 8'hB5, 8'hB8, 8'h77, 8'hDF, 8'h00, 8'h01,
                            8'hF2, 8'hFF, 8'h5A, 8'hF6, 8'h12};
    foreach (seq[i]) send_byte(seq[i]);
    drain();
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) send_byte(pick_byte());
    drain();
  endtask

  task automatic test_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_left = 300;
    send_byte(8'hF3);
    send_byte(8'hB8);
    send_byte(8'h3C);
    for (int i = 0; i < 30; i++) send_byte(pick_byte());
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    out_stall <= (hold_left > 1) || ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    song_event_t got, want;
    got = '{out_event_kind, out_target_chip, out_register_index, out_event_value,
            out_stream_offset, out_last_of_run};
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected event %p", got);
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    loop_on = 1'b0;
    short_value = 8'h00;
    cur_chip = 3'd0;
    phase = PH_OP;
    run_left = 0;
    run_reg = 8'h00;
    byte_pos = '0;
    loop_pos = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_chip0_and_markers();
    test_chip_tables();
    write_cfg(CFG_LOOP_ENABLE, 8'h00);
    write_cfg(CFG_SHORT_DEFAULT, 8'h00);
    test_random(50, 0, 0);
    write_cfg(CFG_SHORT_DEFAULT, 8'($urandom_range(255)));
    test_random(50, 65, 0);
    write_cfg(CFG_LOOP_ENABLE, 8'h01);
    test_random(50, 0, 65);
    write_cfg(CFG_SHORT_DEFAULT, 8'($urandom_range(255)));
    test_random(50, 32, 32);
    test_backpressure();
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end
endmodule
`default_nettype wire
